// File: rtl/assert_macros.svh
// Assertion macros shared by the RTL.
// Needs clk and arst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define ASSERT_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, prop, msg)
`define ASSERT_NEVER(lbl, expr, msg)
`endif
`endif

// File: rtl/ddo_pkg.sv
// Types, constants and tables for the differential drive odometry block.
// No dependencies.
package ddo_pkg;

	localparam int CORDIC_STEPS = 16;
	localparam int FRAC_BITS = 16;

	localparam int CW = FRAC_BITS + 4;
	localparam int IW = $clog2(CORDIC_STEPS);
	localparam logic [63:0] CORDIC_GAIN_Q32 = 64'd2608131496;
	localparam logic [63:0] CORDIC_X0_W =
		(CORDIC_GAIN_Q32 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);
	localparam logic [CW-1:0] CORDIC_X0 = CORDIC_X0_W[CW-1:0];

	localparam logic [31:0] ATAN_BAM [30] = '{
		32'd536870912, 32'd316933405, 32'd167458907, 32'd85004756, 32'd42667331,
		32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335086,
		32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41721, 32'd20860,
		32'd10430, 32'd5215, 32'd2607, 32'd1303, 32'd651, 32'd325, 32'd162,
		32'd81, 32'd40, 32'd20, 32'd10, 32'd5, 32'd2, 32'd1
	};

	// serial datapath sizes
	localparam int DIV_W = 42;
	localparam int REM_W = 13;
	localparam int MUL_AW = 32;
	localparam int PROD_W = MUL_AW + CW;
	localparam int SUM_W = PROD_W + 2;
	localparam int CNT_W = $clog2(DIV_W + 1);
	localparam int ENC_SHIFT = 16 + FRAC_BITS;

	// radius 20 mm, axle 57 mm, Q4.12 wheel angles
	// travel = round((L+R) * 2^18 / 25)
	localparam int TRAVEL_SHIFT = 18;
	localparam logic [REM_W-1:0] DIV_TRAVEL = 13'd25;
	localparam logic [DIV_W-1:0] RND_TRAVEL = 42'd12;
	// turn = (R-L)*58556 + round((R-L)*2481/4864)
	localparam logic signed [33:0] TURN_WHOLE = 34'sd58556;
	localparam logic [DIV_W-1:0] TURN_FRAC_NUM = 42'd2481;
	localparam logic [REM_W-1:0] DIV_TURN = 13'd4864;
	localparam logic [DIV_W-1:0] RND_TURN = 42'd2432;
	localparam logic [REM_W-1:0] DIV_MS = 13'd1000;
	localparam logic [DIV_W-1:0] RND_MS = 42'd500;

	localparam logic [1:0] OP_ENC = 2'd0;
	localparam logic [1:0] OP_ACC = 2'd1;
	localparam logic [1:0] OP_CLR = 2'd2;
	localparam logic [1:0] OP_RSVD = 2'd3;

	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_ACCEL_BIAS = 1'b1;
	localparam logic [9:0] TIME_STEP_RST = 10'd64;

	typedef struct packed {
		logic [1:0] operation;
		logic signed [15:0] left_wheel_delta;
		logic signed [15:0] right_wheel_delta;
		logic signed [15:0] accel_forward;
	} in_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic [31:0] heading_angle;
		logic source;
	} out_t;

	function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] v);
		logic signed [SUM_W-1:0] hi;
		logic signed [SUM_W-1:0] lo;
		hi = SUM_W'(32'sh7fffffff);
		lo = SUM_W'(-33'sh080000000);
		if (v > hi) begin
			return 32'sh7fffffff;
		end else if (v < lo) begin
			return 32'sh80000000;
		end
		return v[31:0];
	endfunction

endpackage

// File: rtl/differential_drive_odometry.sv
// Dead-reckoning odometry: encoder pose, accelerometer pose, shared bit-serial math.
// Depends on ddo_pkg and assert_macros.svh.
//
// Input channel in_valid/in_stall/in_data takes one word: encoder update, accelerometer
// update or clear. Output channel out_valid/out_stall/out_data gives one word for each
// input word: the reported pose, the encoder heading and its source.
// Configuration: cfg_wen writes cfg_wdata to register cfg_index (0 time step in ms,
// 1 accelerometer bias); the user must write only while the block is idle, which the block does not enforce.
// One word is worked on at a time; in_stall is high from acceptance until the result
// is loaded into the output register, so no new word is taken while one is in work.
// The math runs on a restoring divider that retires one quotient bit per cycle and a
// shift-add multiplier that takes one multiplier bit per cycle; the sine/cosine
// rotator runs its 16 steps alongside the first divide or multiply.
// Reset clears all pose state, speed and heading and loads the register defaults.
// A held output word stays in place while out_stall is high; the next input word is
// still taken, and its result waits in the last step until the output register frees.
`include "assert_macros.svh"

module differential_drive_odometry (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  ddo_pkg::in_t in_data,
	output logic out_valid,
	input  logic out_stall,
	output ddo_pkg::out_t out_data,
	input  logic cfg_wen,
	input  logic [ddo_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0] cfg_wdata
);
	import ddo_pkg::*;

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_E_TDIV = 4'd1;
	localparam logic [3:0] ST_E_FDIV = 4'd2;
	localparam logic [3:0] ST_E_XMUL = 4'd3;
	localparam logic [3:0] ST_E_YMUL = 4'd4;
	localparam logic [3:0] ST_A_EMUL = 4'd5;
	localparam logic [3:0] ST_A_VDIV = 4'd6;
	localparam logic [3:0] ST_A_SMUL = 4'd7;
	localparam logic [3:0] ST_A_TDIV = 4'd8;
	localparam logic [3:0] ST_A_XMUL = 4'd9;
	localparam logic [3:0] ST_A_YMUL = 4'd10;
	localparam logic [3:0] ST_FIN    = 4'd11;

	localparam logic [CNT_W-1:0] DIV_LEN = CNT_W'(DIV_W);
	localparam logic [CNT_W-1:0] MUL_LEN = CNT_W'(CW);

	logic [3:0] st_q, st_next;
	logic [CNT_W-1:0] cnt_q;
	in_t item_q;
	logic [9:0] tstep_q;
	logic signed [15:0] bias_q;
	logic signed [31:0] enc_x_q, enc_y_q, acc_x_q, acc_y_q, speed_q;
	logic [31:0] head_q, turn_q, trav_q;
	logic tsign_q, psign_q;
	logic [MUL_AW-1:0] mul_a_q;
	logic [CW-1:0] mul_b_q;
	logic [PROD_W-1:0] prod_q;
	logic [DIV_W-1:0] nq_q;
	logic [REM_W-1:0] rem_q;
	logic signed [CW-1:0] cx_q, cy_q, cos_q, sin_q;
	logic signed [31:0] cz_q;
	logic [1:0] quad_q;
	logic [IW-1:0] citer_q;
	logic cbusy_q;
	out_t out_q;
	logic out_valid_q;

	logic in_acc, is_div, is_mul, unit_active, load_en, step_en, last_step, fin_go, op_enc;
	logic [CNT_W-1:0] unit_len;
	logic [REM_W-1:0] div_d;
	logic [REM_W:0] div_t;
	logic div_ge;
	logic signed [16:0] swh, dwh, ewh;
	logic [16:0] s_mag, d_mag, e_mag;
	logic signed [33:0] turn_full;
	logic [CW-1:0] c_mag, s_mag_t;
	logic [PROD_W:0] step_rnd;
	logic signed [SUM_W-1:0] step_s, pos_sum, spd_sum, dv_s;
	logic signed [31:0] pos_base, pos_new, speed_new;
	logic [31:0] sp_mag, trav_sat, head_sum;
	logic signed [CW-1:0] cdx, cdy, cnx, cny, map_c, map_s;
	logic signed [31:0] cnz;
	logic [31:0] qa;

	assign in_acc = in_valid && !in_stall;
	assign in_stall = (st_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data = out_q;
	assign op_enc = (item_q.operation == OP_ENC);

	always_comb begin
		is_div = (st_q == ST_E_TDIV) || (st_q == ST_E_FDIV) ||
			(st_q == ST_A_VDIV) || (st_q == ST_A_TDIV);
		is_mul = (st_q == ST_E_XMUL) || (st_q == ST_E_YMUL) || (st_q == ST_A_EMUL) ||
			(st_q == ST_A_SMUL) || (st_q == ST_A_XMUL) || (st_q == ST_A_YMUL);
		unit_active = is_div || is_mul;
		unit_len = is_div ? DIV_LEN : MUL_LEN;
		load_en = unit_active && (cnt_q == '0);
		step_en = unit_active && (cnt_q != '0);
		last_step = step_en && (cnt_q == unit_len);
		fin_go = (st_q == ST_FIN) && (!out_valid_q || !out_stall);
	end

	always_comb begin
		unique case (st_q)
			ST_E_TDIV: st_next = ST_E_FDIV;
			ST_E_FDIV: st_next = ST_E_XMUL;
			ST_E_XMUL: st_next = ST_E_YMUL;
			ST_A_EMUL: st_next = ST_A_VDIV;
			ST_A_VDIV: st_next = ST_A_SMUL;
			ST_A_SMUL: st_next = ST_A_TDIV;
			ST_A_TDIV: st_next = ST_A_XMUL;
			ST_A_XMUL: st_next = ST_A_YMUL;
			default:   st_next = ST_FIN;
		endcase
	end

	// restoring divider step, one quotient bit per cycle
	always_comb begin
		case (st_q)
			ST_E_TDIV: div_d = DIV_TRAVEL;
			ST_E_FDIV: div_d = DIV_TURN;
			default:   div_d = DIV_MS;
		endcase
		div_t = {rem_q, nq_q[DIV_W-1]};
		div_ge = (div_t >= {1'b0, div_d});
	end

	// operand preparation and pose arithmetic
	always_comb begin
		swh = 17'(item_q.left_wheel_delta) + 17'(item_q.right_wheel_delta);
		dwh = 17'(item_q.right_wheel_delta) - 17'(item_q.left_wheel_delta);
		ewh = 17'(item_q.accel_forward) - 17'(bias_q);
		s_mag = swh[16] ? 17'(-swh) : 17'(swh);
		d_mag = dwh[16] ? 17'(-dwh) : 17'(dwh);
		e_mag = ewh[16] ? 17'(-ewh) : 17'(ewh);
		turn_full = 34'(dwh) * TURN_WHOLE +
			(dwh[16] ? -34'(nq_q[15:0]) : 34'(nq_q[15:0]));
		c_mag = cos_q[CW-1] ? CW'(-cos_q) : CW'(cos_q);
		s_mag_t = sin_q[CW-1] ? CW'(-sin_q) : CW'(sin_q);

		if (op_enc) begin
			step_rnd = ({1'b0, prod_q} + ((PROD_W+1)'(1) << (ENC_SHIFT - 1))) >> ENC_SHIFT;
		end else begin
			step_rnd = ({1'b0, prod_q} + ((PROD_W+1)'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
		end
		step_s = psign_q ? -$signed({1'b0, step_rnd}) : $signed({1'b0, step_rnd});
		if (st_q == ST_FIN) begin
			pos_base = op_enc ? enc_y_q : acc_y_q;
		end else begin
			pos_base = op_enc ? enc_x_q : acc_x_q;
		end
		pos_sum = SUM_W'(pos_base) + step_s;
		pos_new = sat32(pos_sum);

		dv_s = tsign_q ? -$signed(SUM_W'({1'b0, nq_q})) : $signed(SUM_W'({1'b0, nq_q}));
		spd_sum = SUM_W'(speed_q) + dv_s;
		speed_new = sat32(spd_sum);
		sp_mag = speed_new[31] ? 32'(-33'(speed_new)) : 32'(speed_new);

		if (!tsign_q && (nq_q > DIV_W'(32'h7fffffff))) begin
			trav_sat = 32'h7fffffff;
		end else if (tsign_q && (nq_q > DIV_W'(32'h80000000))) begin
			trav_sat = 32'h80000000;
		end else begin
			trav_sat = nq_q[31:0];
		end
		head_sum = head_q + turn_q;
	end

	// rotation-mode CORDIC step and quadrant fold
	always_comb begin
		cdx = cy_q >>> citer_q;
		cdy = cx_q >>> citer_q;
		if (!cz_q[31]) begin
			cnx = cx_q - cdx;
			cny = cy_q + cdy;
			cnz = cz_q - $signed(ATAN_BAM[citer_q]);
		end else begin
			cnx = cx_q + cdx;
			cny = cy_q - cdy;
			cnz = cz_q + $signed(ATAN_BAM[citer_q]);
		end
		case (quad_q)
			2'd0: begin map_c = cnx;  map_s = cny;  end
			2'd1: begin map_c = -cny; map_s = cnx;  end
			2'd2: begin map_c = -cnx; map_s = -cny; end
			default: begin map_c = cny; map_s = -cnx; end
		endcase
		qa = head_q + 32'h2000_0000;
	end

	// control, configuration and pose state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			cnt_q <= '0;
			cbusy_q <= 1'b0;
			citer_q <= '0;
			out_valid_q <= 1'b0;
			tstep_q <= TIME_STEP_RST;
			bias_q <= '0;
			enc_x_q <= '0;
			enc_y_q <= '0;
			head_q <= '0;
			acc_x_q <= '0;
			acc_y_q <= '0;
			speed_q <= '0;
		end else begin
			if (cfg_wen) begin
				unique case (cfg_index)
					REG_TIME_STEP:  tstep_q <= cfg_wdata[9:0];
					REG_ACCEL_BIAS: bias_q <= cfg_wdata;
					default: ;
				endcase
			end
			out_valid_q <= fin_go || (out_valid_q && out_stall);
			if (cbusy_q) begin
				citer_q <= citer_q + IW'(1);
				if (citer_q == IW'(CORDIC_STEPS - 1)) begin
					cbusy_q <= 1'b0;
				end
			end
			if (in_acc) begin
				cnt_q <= '0;
				if (in_data.operation == OP_ENC) begin
					st_q <= ST_E_TDIV;
				end else if (in_data.operation == OP_ACC) begin
					st_q <= ST_A_EMUL;
				end else begin
					st_q <= ST_FIN;
				end
				if ((in_data.operation == OP_ENC) || (in_data.operation == OP_ACC)) begin
					cbusy_q <= 1'b1;
					citer_q <= '0;
				end
			end
			if (load_en) begin
				cnt_q <= CNT_W'(1);
				if (st_q == ST_A_SMUL) begin
					speed_q <= speed_new;
				end
				if (st_q == ST_E_YMUL) begin
					enc_x_q <= pos_new;
				end
				if (st_q == ST_A_YMUL) begin
					acc_x_q <= pos_new;
				end
			end
			if (step_en) begin
				if (last_step) begin
					st_q <= st_next;
					cnt_q <= '0;
				end else begin
					cnt_q <= cnt_q + CNT_W'(1);
				end
			end
			if (fin_go) begin
				st_q <= ST_IDLE;
				case (item_q.operation)
					OP_ENC: begin
						enc_y_q <= pos_new;
						head_q <= head_sum;
					end
					OP_ACC: acc_y_q <= pos_new;
					OP_CLR: begin
						enc_x_q <= '0;
						enc_y_q <= '0;
						head_q <= '0;
						acc_x_q <= '0;
						acc_y_q <= '0;
						speed_q <= '0;
					end
					default: ;
				endcase
			end
		end
	end

	// serial datapath
	always_ff @(posedge clk) begin
		if (in_acc) begin
			item_q <= in_data;
			quad_q <= qa[31:30];
			cz_q <= $signed(head_q - {qa[31:30], 30'd0});
			cx_q <= $signed(CORDIC_X0);
			cy_q <= '0;
		end
		if (cbusy_q) begin
			cx_q <= cnx;
			cy_q <= cny;
			cz_q <= cnz;
			if (citer_q == IW'(CORDIC_STEPS - 1)) begin
				cos_q <= map_c;
				sin_q <= map_s;
			end
		end
		if (load_en) begin
			rem_q <= '0;
			prod_q <= '0;
			case (st_q)
				ST_E_TDIV: begin
					tsign_q <= swh[16];
					nq_q <= (DIV_W'(s_mag) << TRAVEL_SHIFT) + RND_TRAVEL;
				end
				ST_E_FDIV: begin
					trav_q <= nq_q[31:0];
					nq_q <= DIV_W'(d_mag) * TURN_FRAC_NUM + RND_TURN;
				end
				ST_E_XMUL: begin
					turn_q <= turn_full[31:0];
					mul_a_q <= trav_q;
					mul_b_q <= c_mag;
					psign_q <= tsign_q ^ cos_q[CW-1];
				end
				ST_A_EMUL: begin
					tsign_q <= ewh[16];
					mul_a_q <= MUL_AW'(e_mag);
					mul_b_q <= CW'(tstep_q);
				end
				ST_A_VDIV: nq_q <= (DIV_W'(prod_q) << 8) + RND_MS;
				ST_A_SMUL: begin
					tsign_q <= speed_new[31];
					mul_a_q <= sp_mag;
					mul_b_q <= CW'(tstep_q);
				end
				ST_A_TDIV: nq_q <= DIV_W'(prod_q) + RND_MS;
				ST_A_XMUL: begin
					trav_q <= trav_sat;
					mul_a_q <= trav_sat;
					mul_b_q <= c_mag;
					psign_q <= tsign_q ^ cos_q[CW-1];
				end
				default: begin
					// y pass: x was committed from the product just finished
					mul_a_q <= trav_q;
					mul_b_q <= s_mag_t;
					psign_q <= tsign_q ^ sin_q[CW-1];
				end
			endcase
		end
		if (step_en && is_div) begin
			rem_q <= div_ge ? REM_W'(div_t - {1'b0, div_d}) : REM_W'(div_t);
			nq_q <= {nq_q[DIV_W-2:0], div_ge};
		end
		if (step_en && is_mul) begin
			prod_q <= (prod_q << 1) + (mul_b_q[CW-1] ? PROD_W'(mul_a_q) : PROD_W'(0));
			mul_b_q <= mul_b_q << 1;
		end
		if (fin_go) begin
			case (item_q.operation)
				OP_ENC: out_q <= '{enc_x_q, pos_new, head_sum, 1'b0};
				OP_ACC: out_q <= '{acc_x_q, pos_new, head_q, 1'b1};
				OP_CLR: out_q <= '{32'sd0, 32'sd0, 32'd0, 1'b0};
				default: out_q <= '{enc_x_q, enc_y_q, head_q, 1'b0};
			endcase
		end
	end

	`ASSERT_ALWAYS(a_trig_ready, ((st_q == ST_E_XMUL) || (st_q == ST_A_XMUL)) |-> !cbusy_q, "cosine used before rotator finished")
	`ASSERT_ALWAYS(a_rotator_owned, cbusy_q |-> ((st_q != ST_IDLE) && (st_q != ST_FIN)), "rotator busy outside an update")
	`ASSERT_NEVER(a_cnt_range, cnt_q > DIV_LEN, "step counter past divider length")
	`ASSERT_ALWAYS(a_fin_holds, ((st_q == ST_FIN) && out_valid_q && out_stall) |=> (st_q == ST_FIN), "result overwrote a held word")

endmodule

// File: tb/ddo_checker.sv
// Checker for the odometry block: watches both channels, predicts each result
// word from its own model of the pose math and compares. Depends on ddo_pkg.
module ddo_checker (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_stall,
	input  ddo_pkg::in_t in_data,
	input  logic out_valid,
	input  logic out_stall,
	input  ddo_pkg::out_t out_data,
	input  logic cfg_wen,
	input  logic [ddo_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0] cfg_wdata,
	output int errors,
	output int pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import ddo_pkg::*;

	localparam longint ATAN [16] = '{536870912, 316933405, 167458907, 85004756,
		42667331, 21354465, 10679838, 5340245, 2670163, 1335086, 667544, 333772,
		166886, 83443, 41721, 20860};

	out_t pose_q[$];
	longint step_ms, bias;
	longint ex, ey, ax, ay, spd;
	logic [31:0] hdg;

	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint round_div(longint num, longint den);
		if (num >= 0) return (num + den / 2) / den;
		return -((-num + den / 2) / den);
	endfunction

	task automatic rotate(input logic [31:0] ang, output longint c, output longint s);
		logic [1:0] q;
		logic [31:0] r;
		longint z, x, y, dx, dy;
		q = 2'((ang + 32'h20000000) >> 30);
		r = ang - (32'(q) << 30);
		z = longint'(signed'(r));
		x = (64'd2608131496 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);
		y = 0;
		for (int i = 0; i < 16; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= ATAN[i];
			end else begin
				x += dx; y -= dy; z += ATAN[i];
			end
		end
		case (q)
			2'd0: begin c = x; s = y; end
			2'd1: begin c = -y; s = x; end
			2'd2: begin c = -x; s = -y; end
			default: begin c = y; s = -x; end
		endcase
	endtask

	task automatic predict(input in_t w);
		longint l, r, c, s, trav, turn, dv;
		out_t o;
		l = w.left_wheel_delta;
		r = w.right_wheel_delta;
		o.source = 1'b0;
		o.pos_x = ex[31:0];
		o.pos_y = ey[31:0];
		if (w.operation == OP_ENC) begin
			rotate(hdg, c, s);
			trav = round_div((l + r) * 20 * 64'sd4294967296, 2 * 1000 * 4096);
			turn = round_div((r - l) * 20 * 683565276, 57 * 4096);
			ex = clamp32(ex + round_div(trav * c, 64'sd1 << (16 + FRAC_BITS)));
			ey = clamp32(ey + round_div(trav * s, 64'sd1 << (16 + FRAC_BITS)));
			hdg = hdg + turn[31:0];
			o.pos_x = ex[31:0];
			o.pos_y = ey[31:0];
		end else if (w.operation == OP_ACC) begin
			rotate(hdg, c, s);
			dv = round_div((longint'(w.accel_forward) - bias) * 256 * step_ms, 1000);
			spd = clamp32(spd + dv);
			trav = clamp32(round_div(spd * step_ms, 1000));
			ax = clamp32(ax + round_div(trav * c, 64'sd1 << FRAC_BITS));
			ay = clamp32(ay + round_div(trav * s, 64'sd1 << FRAC_BITS));
			o.pos_x = ax[31:0];
			o.pos_y = ay[31:0];
			o.source = 1'b1;
		end else if (w.operation == OP_CLR) begin
			ex = 0; ey = 0; hdg = 0; ax = 0; ay = 0; spd = 0;
			o.pos_x = 0;
			o.pos_y = 0;
		end
		o.heading_angle = hdg;
		pose_q.push_back(o);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_ms = 64; bias = 0;
			ex = 0; ey = 0; ax = 0; ay = 0; spd = 0; hdg = 0;
			errors = 0;
			pose_q.delete();
			pending = 0;
		end else begin
			if (cfg_wen) begin
				if (cfg_index == REG_TIME_STEP) step_ms = cfg_wdata[9:0];
				else bias = longint'(signed'(cfg_wdata));
			end
			if (in_valid && !in_stall) predict(in_data);
			if (out_valid && !out_stall) begin
				if (pose_q.size() == 0) begin
					errors++;
					if (errors <= 10) $display("unexpected word %p", out_data);
				end else begin
					out_t e;
					e = pose_q.pop_front();
					if (e !== out_data) begin
						errors++;
						if (errors <= 10) $display("mismatch exp %p got %p", e, out_data);
					end
				end
			end
			pending = pose_q.size();
		end
	end
endmodule

// File: tb/tb.sv
// Top of the odometry testbench: clock, reset, stimulus, verdict.
// Depends on ddo_pkg, ddo_checker and differential_drive_odometry.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import ddo_pkg::*;

	logic clk = 0, arst_n = 0;
	logic in_valid = 0, in_stall, out_valid, out_stall = 0;
	in_t in_data = '0;
	out_t out_data;
	logic cfg_wen = 0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_TIME_STEP;
	logic [15:0] cfg_wdata = '0;
	int errors, pending;

	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	differential_drive_odometry u_dut (.*);
	ddo_checker u_chk (.*);

	function automatic int gap_len();
		int p;
		p = $urandom_range(99);
		if (p < 40) return 0;
		if (p < 92) return $urandom_range(3, 1);
		return $urandom_range(60, 10);
	endfunction

	// receiver stalls at random; some phases run with none
	logic calm = 0;
	always @(posedge clk) begin
		if ($urandom_range(499) == 0) calm <= ~calm;
		out_stall <= calm ? 1'b0 : ($urandom_range(99) < 25);
	end

	// valid stays up after acceptance only when the next word follows at once
	task automatic send(input in_t w);
		int g;
		g = gap_len();
		if (g != 0) begin
			in_valid <= 0;
			repeat (g) @(posedge clk);
		end
		in_valid <= 1;
		in_data <= w;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic drain();
		in_valid <= 0;
		do @(negedge clk); while (pending != 0);
		@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] v);
		drain();
		cfg_wen <= 1;
		cfg_index <= idx;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_wen <= 0;
	endtask

	function automatic logic [15:0] pick16();
		case ($urandom_range(5))
			0: return 16'h7fff;
			1: return 16'h8000;
			2: return 16'($urandom_range(64));
			3: return -16'($urandom_range(64));
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic in_t rand_word();
		in_t w;
		int p;
		p = $urandom_range(99);
		w.operation = p < 50 ? OP_ENC : p < 90 ? OP_ACC : p < 96 ? OP_CLR : OP_RSVD;
		w.left_wheel_delta = pick16();
		w.right_wheel_delta = $urandom_range(3) == 0 ? pick16() : w.left_wheel_delta
			+ 16'($urandom_range(200)) - 16'd100;
		w.accel_forward = pick16();
		return w;
	endfunction

	initial begin
		in_t w;
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed: extremes, every operation, unused code, clear
		send('{OP_ENC, 16'h7fff, 16'h7fff, 16'h0000});
		send('{OP_ENC, 16'h8000, 16'h8000, 16'hffff});
		send('{OP_ENC, 16'h8000, 16'h7fff, 16'h0000});
		send('{OP_ENC, 16'h7fff, 16'h8000, 16'h0000});
		send('{OP_ENC, 16'h0000, 16'h1000, 16'h0000});
		send('{OP_ACC, 16'hffff, 16'h0000, 16'h7fff});
		send('{OP_ACC, 16'h0000, 16'hffff, 16'h8000});
		send('{OP_RSVD, 16'h1234, 16'hffff, 16'hffff});
		send('{OP_CLR, 16'hffff, 16'hffff, 16'h7fff});
		write_reg(REG_TIME_STEP, 16'd1000);
		write_reg(REG_ACCEL_BIAS, 16'h8000);
		for (int i = 0; i < 8; i++) send('{OP_ACC, 16'h0, 16'h0, 16'h7fff});
		write_reg(REG_ACCEL_BIAS, 16'h7fff);
		for (int i = 0; i < 8; i++) send('{OP_ACC, 16'h0, 16'h0, 16'h8000});
		write_reg(REG_TIME_STEP, 16'd0);
		send('{OP_ACC, 16'h0, 16'h0, 16'h1234});
		send('{OP_CLR, 16'h0, 16'h0, 16'h0});
		// random phases across settings, draining before each write
		for (int ph = 0; ph < 7; ph++) begin
			case (ph)
				0: write_reg(REG_TIME_STEP, 16'd1);
				1: write_reg(REG_TIME_STEP, 16'($urandom_range(1000, 1)));
				2: write_reg(REG_TIME_STEP, 16'hfc00 | 16'($urandom_range(1023)));
				default: write_reg(REG_TIME_STEP, 16'($urandom_range(1023)));
			endcase
			write_reg(REG_ACCEL_BIAS, 16'($urandom));
			for (int i = 0; i < 150; i++) begin
				w = rand_word();
				send(w);
			end
		end
		drain();
		if (errors == 0) $display("tb: done, clean");
		else $display("tb: done, errors");
		$finish;
	end

	initial begin
		#10000000;
		$display("tb: done, errors");
		$finish;
	end
endmodule
